// ===== rtl/complex_tensor_field_product_unit_assert.svh =====
// ----------------------------------------------------------------------------
// complex tensor field product unit: assertion macros
// shorthand for the concurrent checks at the end of the top level
// ----------------------------------------------------------------------------
`ifndef COMPLEX_TENSOR_FIELD_PRODUCT_UNIT_ASSERT_SVH
`define COMPLEX_TENSOR_FIELD_PRODUCT_UNIT_ASSERT_SVH

// consequent must hold in the same cycle as the antecedent
`define CTFP_ASSERT_NOW(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("ctfp: same-cycle check failed");

// consequent must hold in the cycle after the antecedent
`define CTFP_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("ctfp: next-cycle check failed");

`endif

// ===== rtl/ctfp_pkg.sv =====
// ----------------------------------------------------------------------------
// ctfp_pkg
// shared types, widths and codes of the complex tensor field product unit
// ----------------------------------------------------------------------------
package ctfp_pkg;

   localparam int POINTS       = 4096;
   localparam int SAMPLE_WIDTH = 24;

   localparam int FIELD_W = 24;
   localparam int SAT_W   = (SAMPLE_WIDTH > FIELD_W) ? FIELD_W : SAMPLE_WIDTH;
   localparam int IDX_W   = 12;
   localparam int SLOT_W  = 4;
   localparam int FRAC_W  = 5;
   localparam int DIM     = 3;
   localparam int COL_W   = 2;
   localparam int PROD_W  = 2 * FIELD_W;
   localparam int TERM_W  = PROD_W + 1;
   localparam int ACC_W   = TERM_W + 2;

   localparam int MEM_DEPTH = (POINTS > (2 ** IDX_W)) ? (2 ** IDX_W) : POINTS;
   localparam int MEM_AW    = (MEM_DEPTH > 1) ? $clog2(MEM_DEPTH) : 1;

   localparam logic [FRAC_W-1:0] FRAC_RESET = FRAC_W'(16);

   localparam logic CMD_LOAD    = 1'b0;
   localparam logic CMD_COMPUTE = 1'b1;

   typedef logic signed [FIELD_W-1:0] sample_type;
   typedef logic signed [ACC_W-1:0]   acc_type;

   localparam acc_type SAT_HI = ACC_W'((64'sd1 <<< (SAT_W - 1)) - 64'sd1);
   localparam acc_type SAT_LO = ACC_W'(-(64'sd1 <<< (SAT_W - 1)));

   // re in the upper half, im in the lower half, as stored
   typedef struct packed {
      sample_type re;
      sample_type im;
   } cplx_type;

   typedef cplx_type [DIM-1:0] cvec_type;

   typedef enum logic [SLOT_W-1:0] {
      SLOT_XX = 4'd0,
      SLOT_XY = 4'd1,
      SLOT_XZ = 4'd2,
      SLOT_YX = 4'd3,
      SLOT_YY = 4'd4,
      SLOT_YZ = 4'd5,
      SLOT_ZX = 4'd6,
      SLOT_ZY = 4'd7,
      SLOT_ZZ = 4'd8
   } slot_code_type;

   typedef struct packed {
      logic             ok;
      logic [COL_W-1:0] row;
      logic [COL_W-1:0] col;
   } slot_type;

   // stage load enables handed to the lanes
   typedef struct packed {
      logic s1;
      logic s2;
      logic s3;
      logic s4;
   } stage_en_type;

   // one tensor word write into a lane
   typedef struct packed {
      logic [DIM-1:0]    col_we;
      logic [MEM_AW-1:0] addr;
      cplx_type          data;
   } wr_type;

   function automatic slot_type slot_decode(input logic [SLOT_W-1:0] slot);
      slot_type d;
      d = '0;
      case (slot_code_type'(slot))
         SLOT_XX: d = '{ok: 1'b1, row: 2'd0, col: 2'd0};
         SLOT_XY: d = '{ok: 1'b1, row: 2'd0, col: 2'd1};
         SLOT_XZ: d = '{ok: 1'b1, row: 2'd0, col: 2'd2};
         SLOT_YX: d = '{ok: 1'b1, row: 2'd1, col: 2'd0};
         SLOT_YY: d = '{ok: 1'b1, row: 2'd1, col: 2'd1};
         SLOT_YZ: d = '{ok: 1'b1, row: 2'd1, col: 2'd2};
         SLOT_ZX: d = '{ok: 1'b1, row: 2'd2, col: 2'd0};
         SLOT_ZY: d = '{ok: 1'b1, row: 2'd2, col: 2'd1};
         SLOT_ZZ: d = '{ok: 1'b1, row: 2'd2, col: 2'd2};
         default: d = '0;
      endcase
      return d;
   endfunction

endpackage

// ===== rtl/ctfp_if.sv =====
// ----------------------------------------------------------------------------
// ctfp channel interfaces
// valid/ready channels for request, response and register write beats
// ----------------------------------------------------------------------------
interface ctfp_req_if;
   logic                                 valid;
   logic                                 ready;
   logic                                 cmd;
   logic [ctfp_pkg::IDX_W-1:0]           point_index;
   logic [ctfp_pkg::SLOT_W-1:0]          tensor_slot;
   logic signed [ctfp_pkg::FIELD_W-1:0]  tensor_re;
   logic signed [ctfp_pkg::FIELD_W-1:0]  tensor_im;
   logic signed [ctfp_pkg::FIELD_W-1:0]  spin_x_re;
   logic signed [ctfp_pkg::FIELD_W-1:0]  spin_x_im;
   logic signed [ctfp_pkg::FIELD_W-1:0]  spin_y_re;
   logic signed [ctfp_pkg::FIELD_W-1:0]  spin_y_im;
   logic signed [ctfp_pkg::FIELD_W-1:0]  spin_z_re;
   logic signed [ctfp_pkg::FIELD_W-1:0]  spin_z_im;

   modport source (
      output valid, cmd, point_index, tensor_slot, tensor_re, tensor_im,
             spin_x_re, spin_x_im, spin_y_re, spin_y_im, spin_z_re, spin_z_im,
      input  ready
   );
   modport sink (
      input  valid, cmd, point_index, tensor_slot, tensor_re, tensor_im,
             spin_x_re, spin_x_im, spin_y_re, spin_y_im, spin_z_re, spin_z_im,
      output ready
   );
endinterface

interface ctfp_rsp_if;
   logic                                 valid;
   logic                                 ready;
   logic signed [ctfp_pkg::FIELD_W-1:0]  field_x_re;
   logic signed [ctfp_pkg::FIELD_W-1:0]  field_x_im;
   logic signed [ctfp_pkg::FIELD_W-1:0]  field_y_re;
   logic signed [ctfp_pkg::FIELD_W-1:0]  field_y_im;
   logic signed [ctfp_pkg::FIELD_W-1:0]  field_z_re;
   logic signed [ctfp_pkg::FIELD_W-1:0]  field_z_im;
   logic                                 saturated;

   modport source (
      output valid, field_x_re, field_x_im, field_y_re, field_y_im,
             field_z_re, field_z_im, saturated,
      input  ready
   );
   modport sink (
      input  valid, field_x_re, field_x_im, field_y_re, field_y_im,
             field_z_re, field_z_im, saturated,
      output ready
   );
endinterface

interface ctfp_csr_if;
   logic                          valid;
   logic                          ready;
   logic [ctfp_pkg::FRAC_W-1:0]   data;

   modport source (output valid, data, input ready);
   modport sink   (input valid, data, output ready);
endinterface

// ===== rtl/complex_tensor_field_product_unit.sv =====
// ----------------------------------------------------------------------------
// complex_tensor_field_product_unit
// per-point complex 3x3 tensor times complex spin vector, fixed point
// ----------------------------------------------------------------------------
// Takes one request beat per cycle while req_if.ready is high and returns one
// response beat per compute request; load requests write one tensor word and
// return nothing. A compute beat passes the read, product, term and row-sum
// registers into the response register and waits for rsp_if.ready. The tensor
// store is nine memories of POINTS words each (one per tensor slot, three per
// row lane), all read at the same point at once, so every compute sees
// its full tensor in a single read and a load followed at once by a compute
// of the same point sees the new word. The three row lanes each do their
// three complex multiplies in parallel; the merge stage shifts each sum right
// by fraction_bits, clips it and ORs the clip flags. The store has no reset
// and no clearing pass: a word must be loaded before a compute reads it.
// Stages: memory read, products, complex terms, row sums, shift and clip
// into the response register. Each stage holds only while the ones after it
// are full, so requests fill empty stages while a response waits to be taken.
// fraction_bits is written through the register port, which never stalls,
// and must only change while no compute is in flight.
// ----------------------------------------------------------------------------
`include "complex_tensor_field_product_unit_assert.svh"

module complex_tensor_field_product_unit (
   input  logic           clock,
   input  logic           reset,
   ctfp_req_if.sink       req_if,
   ctfp_rsp_if.source     rsp_if,
   ctfp_csr_if.sink       csr_if
);

   localparam int STAGES = 5;

   // register port
   logic [ctfp_pkg::FRAC_W-1:0] frac_ff;

   // pipeline occupancy, stage 5 is the response register
   logic [STAGES:1]   v_ff, v_in;
   logic [STAGES:1]   rdy;
   logic [STAGES-1:1] null_ff, null_in;

   logic                       req_acc;
   logic                       load_acc;
   logic                       compute_acc;
   logic                       pt_ok;
   ctfp_pkg::slot_type         slot_dec;
   logic                       wr_en;
   ctfp_pkg::cvec_type         spin_ff, spin_in;
   ctfp_pkg::stage_en_type     lane_en;
   ctfp_pkg::wr_type           lane_wr [ctfp_pkg::DIM];
   ctfp_pkg::acc_type          lane_sum_re [ctfp_pkg::DIM];
   ctfp_pkg::acc_type          lane_sum_im [ctfp_pkg::DIM];
   ctfp_pkg::cvec_type         field;
   logic                       saturated;
   logic                       sat_hit;

   // config beats are always taken
   assign csr_if.ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         frac_ff <= ctfp_pkg::FRAC_RESET;
      end else if (csr_if.valid) begin
         frac_ff <= csr_if.data;
      end
   end

   // ready ripples back from the response side through empty stages
   always_comb begin
      rdy[STAGES] = !v_ff[STAGES] || rsp_if.ready;
      for (int k = STAGES - 1; k >= 1; k--) begin
         rdy[k] = !v_ff[k] || rdy[k+1];
      end
   end

   assign req_if.ready = rdy[1];
   assign req_acc      = req_if.valid && rdy[1];
   assign load_acc     = req_acc && (req_if.cmd == ctfp_pkg::CMD_LOAD);
   assign compute_acc  = req_acc && (req_if.cmd == ctfp_pkg::CMD_COMPUTE);

   // request decode
   assign pt_ok    = int'(req_if.point_index) < ctfp_pkg::POINTS;
   assign slot_dec = ctfp_pkg::slot_decode(req_if.tensor_slot);
   assign wr_en    = load_acc && slot_dec.ok && pt_ok;

   always_comb begin
      for (int r = 0; r < ctfp_pkg::DIM; r++) begin
         lane_wr[r].addr    = req_if.point_index[ctfp_pkg::MEM_AW-1:0];
         lane_wr[r].data.re = req_if.tensor_re;
         lane_wr[r].data.im = req_if.tensor_im;
         lane_wr[r].col_we  = '0;
         if (wr_en && (slot_dec.row == ctfp_pkg::COL_W'(r))) begin
            lane_wr[r].col_we = ctfp_pkg::DIM'(1) << slot_dec.col;
         end
      end
   end

   // valid and out-of-grid flag travel alongside the data
   always_comb begin
      v_in[1]    = compute_acc;
      null_in[1] = !pt_ok;
      for (int k = 2; k <= STAGES; k++) begin
         v_in[k] = v_ff[k-1];
      end
      for (int k = 2; k < STAGES; k++) begin
         null_in[k] = null_ff[k-1];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff <= '0;
      end else begin
         for (int k = 1; k <= STAGES; k++) begin
            if (rdy[k]) begin
               v_ff[k] <= v_in[k];
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      for (int k = 1; k < STAGES; k++) begin
         if (rdy[k]) begin
            null_ff[k] <= null_in[k];
         end
      end
   end

   // spin vector lines up with the memory read data
   always_comb begin
      spin_in[0].re = req_if.spin_x_re;
      spin_in[0].im = req_if.spin_x_im;
      spin_in[1].re = req_if.spin_y_re;
      spin_in[1].im = req_if.spin_y_im;
      spin_in[2].re = req_if.spin_z_re;
      spin_in[2].im = req_if.spin_z_im;
   end

   always_ff @(posedge clock) begin
      if (rdy[1]) begin
         spin_ff <= spin_in;
      end
   end

   always_comb begin
      lane_en.s1 = rdy[1];
      lane_en.s2 = rdy[2];
      lane_en.s3 = rdy[3];
      lane_en.s4 = rdy[4];
   end

   // one lane per tensor row
   for (genvar r = 0; r < ctfp_pkg::DIM; r++) begin : g_lane
      ctfp_lane u_lane (
         .clock   (clock),
         .en      (lane_en),
         .wr      (lane_wr[r]),
         .rd_addr (req_if.point_index[ctfp_pkg::MEM_AW-1:0]),
         .spin    (spin_ff),
         .sum_re  (lane_sum_re[r]),
         .sum_im  (lane_sum_im[r])
      );
   end

   // scale, clip and combine the lanes into the response register
   ctfp_merge u_merge (
      .clock     (clock),
      .en        (rdy[STAGES]),
      .null_pt   (null_ff[STAGES-1]),
      .frac      (frac_ff),
      .sum_re    (lane_sum_re),
      .sum_im    (lane_sum_im),
      .field     (field),
      .saturated (saturated)
   );

   assign rsp_if.valid      = v_ff[STAGES];
   assign rsp_if.field_x_re = field[0].re;
   assign rsp_if.field_x_im = field[0].im;
   assign rsp_if.field_y_re = field[1].re;
   assign rsp_if.field_y_im = field[1].im;
   assign rsp_if.field_z_re = field[2].re;
   assign rsp_if.field_z_im = field[2].im;
   assign rsp_if.saturated  = saturated;

   // a clip flag must come with at least one component at a range limit
   always_comb begin
      sat_hit = 1'b0;
      for (int r = 0; r < ctfp_pkg::DIM; r++) begin
         if (field[r].re == ctfp_pkg::SAT_HI[ctfp_pkg::FIELD_W-1:0] ||
             field[r].re == ctfp_pkg::SAT_LO[ctfp_pkg::FIELD_W-1:0] ||
             field[r].im == ctfp_pkg::SAT_HI[ctfp_pkg::FIELD_W-1:0] ||
             field[r].im == ctfp_pkg::SAT_LO[ctfp_pkg::FIELD_W-1:0]) begin
            sat_hit = 1'b1;
         end
      end
   end

   // clipped response shows a limit value
   `CTFP_ASSERT_NOW(a_sat_at_limit, clock, reset, rsp_if.valid && rsp_if.saturated, sat_hit)
   // a load beat never enters the compute pipeline
   `CTFP_ASSERT_NEXT(a_load_no_beat, clock, reset, load_acc, !v_ff[1])
   // a compute beat always occupies the first stage next cycle
   `CTFP_ASSERT_NEXT(a_compute_enters, clock, reset, compute_acc, v_ff[1])

endmodule

// ===== rtl/ctfp_lane.sv =====
// ----------------------------------------------------------------------------
// ctfp_lane
// one tensor row: three column memories, complex products and the row sum
// ----------------------------------------------------------------------------
module ctfp_lane (
   input  logic                            clock,
   input  ctfp_pkg::stage_en_type          en,
   input  ctfp_pkg::wr_type                wr,
   input  logic [ctfp_pkg::MEM_AW-1:0]     rd_addr,
   input  ctfp_pkg::cvec_type              spin,
   output ctfp_pkg::acc_type               sum_re,
   output ctfp_pkg::acc_type               sum_im
);

   logic signed [ctfp_pkg::TERM_W-1:0] term_re [ctfp_pkg::DIM];
   logic signed [ctfp_pkg::TERM_W-1:0] term_im [ctfp_pkg::DIM];
   ctfp_pkg::acc_type                  sum_re_ff, sum_re_in;
   ctfp_pkg::acc_type                  sum_im_ff, sum_im_in;

   for (genvar c = 0; c < ctfp_pkg::DIM; c++) begin : g_col
      ctfp_pkg::cplx_type                 mem [ctfp_pkg::MEM_DEPTH];
      ctfp_pkg::cplx_type                 word_ff;
      logic signed [ctfp_pkg::PROD_W-1:0] rr_ff, ii_ff, ri_ff, ir_ff;
      logic signed [ctfp_pkg::TERM_W-1:0] tre_ff, tim_ff;

      always_ff @(posedge clock) begin
         if (wr.col_we[c]) begin
            mem[wr.addr] <= wr.data;
         end
         if (en.s1) begin
            word_ff <= mem[rd_addr];
         end
      end

      // one complex multiply: four real products
      always_ff @(posedge clock) begin
         if (en.s2) begin
            rr_ff <= $signed(word_ff.re) * $signed(spin[c].re);
            ii_ff <= $signed(word_ff.im) * $signed(spin[c].im);
            ri_ff <= $signed(word_ff.re) * $signed(spin[c].im);
            ir_ff <= $signed(word_ff.im) * $signed(spin[c].re);
         end
      end

      always_ff @(posedge clock) begin
         if (en.s3) begin
            tre_ff <= ctfp_pkg::TERM_W'(rr_ff) - ctfp_pkg::TERM_W'(ii_ff);
            tim_ff <= ctfp_pkg::TERM_W'(ri_ff) + ctfp_pkg::TERM_W'(ir_ff);
         end
      end

      assign term_re[c] = tre_ff;
      assign term_im[c] = tim_ff;
   end

   always_comb begin
      sum_re_in = '0;
      sum_im_in = '0;
      for (int c = 0; c < ctfp_pkg::DIM; c++) begin
         sum_re_in = sum_re_in + ctfp_pkg::ACC_W'(term_re[c]);
         sum_im_in = sum_im_in + ctfp_pkg::ACC_W'(term_im[c]);
      end
   end

   always_ff @(posedge clock) begin
      if (en.s4) begin
         sum_re_ff <= sum_re_in;
         sum_im_ff <= sum_im_in;
      end
   end

   assign sum_re = sum_re_ff;
   assign sum_im = sum_im_ff;

endmodule

// ===== rtl/ctfp_merge.sv =====
// ----------------------------------------------------------------------------
// ctfp_merge
// scales and clips the row sums of all lanes into the response register
// ----------------------------------------------------------------------------
module ctfp_merge (
   input  logic                          clock,
   input  logic                          en,
   input  logic                          null_pt,
   input  logic [ctfp_pkg::FRAC_W-1:0]   frac,
   input  ctfp_pkg::acc_type             sum_re [ctfp_pkg::DIM],
   input  ctfp_pkg::acc_type             sum_im [ctfp_pkg::DIM],
   output ctfp_pkg::cvec_type            field,
   output logic                          saturated
);

   ctfp_pkg::cvec_type field_ff, field_in;
   logic               sat_ff, sat_in;

   // floor shift then clip; top bit flags a clip
   function automatic logic [ctfp_pkg::FIELD_W:0] finish(
      input ctfp_pkg::acc_type           v,
      input logic [ctfp_pkg::FRAC_W-1:0] s
   );
      ctfp_pkg::acc_type sh;
      logic [ctfp_pkg::FIELD_W:0] r;
      sh = v >>> s;
      if (sh > ctfp_pkg::SAT_HI) begin
         r = {1'b1, ctfp_pkg::SAT_HI[ctfp_pkg::FIELD_W-1:0]};
      end else if (sh < ctfp_pkg::SAT_LO) begin
         r = {1'b1, ctfp_pkg::SAT_LO[ctfp_pkg::FIELD_W-1:0]};
      end else begin
         r = {1'b0, sh[ctfp_pkg::FIELD_W-1:0]};
      end
      return r;
   endfunction

   always_comb begin
      logic [ctfp_pkg::FIELD_W:0] fr, fi;
      field_in = '0;
      sat_in   = 1'b0;
      for (int r = 0; r < ctfp_pkg::DIM; r++) begin
         fr = finish(sum_re[r], frac);
         fi = finish(sum_im[r], frac);
         field_in[r].re = fr[ctfp_pkg::FIELD_W-1:0];
         field_in[r].im = fi[ctfp_pkg::FIELD_W-1:0];
         sat_in = sat_in | fr[ctfp_pkg::FIELD_W] | fi[ctfp_pkg::FIELD_W];
      end
      // point outside the grid: all zero, no clip
      if (null_pt) begin
         field_in = '0;
         sat_in   = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         field_ff <= field_in;
         sat_ff   <= sat_in;
      end
   end

   assign field     = field_ff;
   assign saturated = sat_ff;

endmodule
